/* sv/random_pick_bucket_table_defines.svh */
// assertion helpers shared by the rtl, clocked on clock and held off during reset
`ifndef RANDOM_PICK_BUCKET_TABLE_DEFINES_SVH
`define RANDOM_PICK_BUCKET_TABLE_DEFINES_SVH

// condition must hold at every edge out of reset
`define RPBT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define RPBT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* sv/rpbt_pkg.sv */
package rpbt_pkg;

   localparam int DEF_MAX_BUCKETS = 256;
   localparam int KEY_W           = 32;
   localparam int COUNT_W         = 32;
   localparam int RAND_W          = 32;
   localparam int LIVE_OUT_W      = 9;

   typedef logic [LIVE_OUT_W-1:0] live_out_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DIV,
      S_SEL_WAIT,
      S_MOVE_WAIT
   } state_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [COUNT_W-1:0]      count;
   } entry_type;

endpackage

/* sv/rpbt_divider.sv */
module rpbt_divider #(
   parameter int DIVISOR_W = $clog2(rpbt_pkg::DEF_MAX_BUCKETS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpbt_pkg::RAND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic                       done,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int StepW = $clog2(rpbt_pkg::RAND_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [StepW-1:0]            step_ff;
   logic [rpbt_pkg::RAND_W-1:0] dvd_ff;
   logic [DIVISOR_W-1:0]        dsr_ff;
   logic [DIVISOR_W-1:0]        rem_ff;
   logic [DIVISOR_W-1:0]        rem_in;
   logic [DIVISOR_W:0]          trial;
   logic [DIVISOR_W:0]          diff;

   // restoring division, one quotient bit per cycle, only the remainder is kept
   always_comb begin
      trial = {rem_ff, dvd_ff[rpbt_pkg::RAND_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      if (trial >= {1'b0, dsr_ff}) begin
         rem_in = diff[DIVISOR_W-1:0];
      end else begin
         rem_in = trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == StepW'(rpbt_pkg::RAND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[rpbt_pkg::RAND_W-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* sv/random_pick_bucket_table.sv */
// responses: cmd 3 and select on an empty table answer in the cycle after the accepting edge;
// insert and remove walk the table one entry a cycle, and a freed slot is then refilled
// from the last live entry; select runs the 32-step remainder unit, then reads the entry
// throughput: one command at a time, the next may start in the cycle rsp_valid is high
// reset clears the live count and control only; table contents stay undefined
`include "random_pick_bucket_table_defines.svh"

module random_pick_bucket_table #(
   parameter int MAX_BUCKETS = rpbt_pkg::DEF_MAX_BUCKETS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic signed [rpbt_pkg::KEY_W-1:0]   req_bucket_key,
   input  logic [rpbt_pkg::RAND_W-1:0]         req_random_value,
   output logic                                rsp_valid,
   output logic signed [rpbt_pkg::KEY_W-1:0]   rsp_selected_key,
   output logic [1:0]                          rsp_status,
   output logic [rpbt_pkg::LIVE_OUT_W-1:0]     rsp_live_buckets
);

   localparam int AddrW = $clog2(MAX_BUCKETS);
   localparam int CntW  = $clog2(MAX_BUCKETS + 1);

   typedef logic [CntW-1:0] live_type;

   rpbt_pkg::entry_type mem [MAX_BUCKETS];
   rpbt_pkg::entry_type rd_data_ff;

   rpbt_pkg::state_type state_ff, state_in;
   live_type            live_ff, live_in;
   live_type            idx_ff, idx_in;
   logic                chk_ff, chk_in;
   logic [AddrW-1:0]    chk_addr_ff, chk_addr_in;
   logic [AddrW-1:0]    slot_ff, slot_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic signed [rpbt_pkg::KEY_W-1:0] key_ff, key_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [rpbt_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;

   logic                   mem_we;
   logic [AddrW-1:0]       mem_waddr;
   rpbt_pkg::entry_type    mem_wdata;
   logic                   mem_re;
   logic [AddrW-1:0]       mem_raddr;

   logic                         div_start;
   logic                         div_done;
   logic [CntW-1:0]              div_rem;
   logic                         hit;
   logic [rpbt_pkg::COUNT_W-1:0] cnt_dec;
   live_type                     last_idx;

   rpbt_divider #(
      .DIVISOR_W (CntW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_value),
      .divisor   (live_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // the sequencer never reads and writes in the same cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      hit      = chk_ff && (rd_data_ff.key == key_ff);
      cnt_dec  = rd_data_ff.count - ((rd_data_ff.count != '0) ? 1'b1 : 1'b0);
      last_idx = live_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpbt_pkg::S_IDLE;
         live_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      chk_addr_ff   <= chk_addr_in;
      slot_ff       <= slot_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      chk_in        = 1'b0;
      chk_addr_in   = chk_addr_ff;
      slot_in       = slot_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = chk_addr_ff;
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff[AddrW-1:0];
      div_start     = 1'b0;

      unique case (state_ff)
         rpbt_pkg::S_IDLE: begin
            if (start) begin
               cmd_in        = req_cmd;
               key_in        = req_bucket_key;
               rsp_key_in    = '0;
               rsp_status_in = rpbt_pkg::ST_OK;
               case (req_cmd) inside
                  rpbt_pkg::CMD_INSERT, rpbt_pkg::CMD_REMOVE: begin
                     idx_in   = '0;
                     state_in = rpbt_pkg::S_SCAN;
                  end
                  rpbt_pkg::CMD_SELECT: begin
                     if (live_ff == '0) begin
                        rsp_status_in = rpbt_pkg::ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = rpbt_pkg::S_DIV;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         rpbt_pkg::S_SCAN: begin
            if (hit) begin
               if (cmd_ff == rpbt_pkg::CMD_INSERT) begin
                  mem_we          = 1'b1;
                  mem_wdata.count = (rd_data_ff.count == '1) ? rd_data_ff.count
                                                             : rd_data_ff.count + 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = rpbt_pkg::S_IDLE;
               end else if (cnt_dec != '0) begin
                  mem_we          = 1'b1;
                  mem_wdata.count = cnt_dec;
                  rsp_valid_in    = 1'b1;
                  state_in        = rpbt_pkg::S_IDLE;
               end else begin
                  // bucket emptied: fetch the last live entry to fill the hole
                  mem_re    = 1'b1;
                  mem_raddr = last_idx[AddrW-1:0];
                  slot_in   = chk_addr_ff;
                  state_in  = rpbt_pkg::S_MOVE_WAIT;
               end
            end else if (idx_ff < live_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = idx_ff[AddrW-1:0];
               chk_in      = 1'b1;
               chk_addr_in = idx_ff[AddrW-1:0];
               idx_in      = idx_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = rpbt_pkg::S_IDLE;
               if (cmd_ff == rpbt_pkg::CMD_REMOVE) begin
                  rsp_status_in = rpbt_pkg::ST_MISSING;
               end else if (live_ff >= live_type'(MAX_BUCKETS)) begin
                  rsp_status_in = rpbt_pkg::ST_FULL;
               end else begin
                  mem_we          = 1'b1;
                  mem_waddr       = live_ff[AddrW-1:0];
                  mem_wdata.key   = key_ff;
                  mem_wdata.count = rpbt_pkg::COUNT_W'(1);
                  live_in         = live_ff + 1'b1;
               end
            end
         end

         rpbt_pkg::S_DIV: begin
            if (div_done) begin
               mem_re    = 1'b1;
               mem_raddr = div_rem[AddrW-1:0];
               state_in  = rpbt_pkg::S_SEL_WAIT;
            end
         end

         rpbt_pkg::S_SEL_WAIT: begin
            rsp_key_in   = rd_data_ff.key;
            rsp_valid_in = 1'b1;
            state_in     = rpbt_pkg::S_IDLE;
         end

         rpbt_pkg::S_MOVE_WAIT: begin
            mem_we       = 1'b1;
            mem_waddr    = slot_ff;
            mem_wdata    = rd_data_ff;
            live_in      = last_idx;
            rsp_valid_in = 1'b1;
            state_in     = rpbt_pkg::S_IDLE;
         end

         default: begin
            state_in = rpbt_pkg::S_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != rpbt_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_selected_key = rsp_key_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_live_buckets = rpbt_pkg::live_out_type'(live_ff);

   `RPBT_ASSERT_ALWAYS(a_live_bound, live_ff <= live_type'(MAX_BUCKETS), "live count overflow")
   `RPBT_ASSERT_IMPLIES(a_scan_bound, state_ff == rpbt_pkg::S_SCAN, idx_ff <= live_ff,
      "scan index past live count")
   `RPBT_ASSERT_IMPLIES(a_move_live, state_ff == rpbt_pkg::S_MOVE_WAIT, live_ff != '0,
      "slot refill with empty table")
   `RPBT_ASSERT_IMPLIES(a_err_key, rsp_valid && (rsp_status != rpbt_pkg::ST_OK),
      rsp_selected_key == '0, "key returned on error beat")

endmodule
